@@ rtl/rosi_pkg.sv @@
// ============================================================================
// rosi_pkg
// Shared widths, configuration register indexes and saturation limits for
// the ray / oriented box slab intersection block.
// ============================================================================
package rosi_pkg;

    localparam int POS_W      = 32;   // Q16.16 positions and distances
    localparam int AXIS_W     = 48;   // three packed Q1.15 components
    localparam int COMP_W     = 16;   // one Q1.15 component
    localparam int HALF_W     = 31;   // unsigned Q15.16 half length
    localparam int THR_W      = 17;   // unsigned Q1.16 parallel threshold
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ORIGIN_X    = 3'd0;
    localparam cfg_index_t CFG_ORIGIN_Y    = 3'd1;
    localparam cfg_index_t CFG_ORIGIN_Z    = 3'd2;
    localparam cfg_index_t CFG_DIRECTION_X = 3'd3;
    localparam cfg_index_t CFG_DIRECTION_Y = 3'd4;
    localparam cfg_index_t CFG_DIRECTION_Z = 3'd5;
    localparam cfg_index_t CFG_PAR_THRESH  = 3'd6;

    localparam logic signed [POS_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

@@ rtl/rosi_box_if.sv @@
// ============================================================================
// rosi_box_if
// Box word channel: center, three unit axes and three half lengths.
// ============================================================================
interface rosi_box_if
    import rosi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  center_x;
    logic signed [POS_W-1:0]  center_y;
    logic signed [POS_W-1:0]  center_z;
    logic [AXIS_W-1:0]        axis_first;
    logic [AXIS_W-1:0]        axis_second;
    logic [AXIS_W-1:0]        axis_third;
    logic [HALF_W-1:0]        half_first;
    logic [HALF_W-1:0]        half_second;
    logic [HALF_W-1:0]        half_third;

    modport source (
        output valid, center_x, center_y, center_z,
        output axis_first, axis_second, axis_third,
        output half_first, half_second, half_third,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z,
        input  axis_first, axis_second, axis_third,
        input  half_first, half_second, half_third,
        output ready
    );
endinterface

@@ rtl/rosi_hit_if.sv @@
// ============================================================================
// rosi_hit_if
// Result word channel: hit flag and ray distance.
// ============================================================================
interface rosi_hit_if
    import rosi_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [POS_W-1:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

@@ rtl/ray_obb_slab_intersect.sv @@
// ============================================================================
// ray_obb_slab_intersect
// Slab test of one configured ray against a stream of oriented boxes.
// ============================================================================
// The block takes one box word per clock cycle while box.ready is high and
// returns one result word per box, in order. Six restoring dividers of 31
// one-bit stages each run side by side, two per box axis. Every stage
// carries its own valid bit and may fill a bubble ahead of it, so a stalled
// result side only holds up the stages that are full. The ray origin,
// direction and parallel threshold are written through the plain register
// port and must only change while no box is in flight. A miss returns hit 0
// and distance 0; a ray that is parallel to all three slabs and lies inside
// them all returns hit 1 with the largest distance.

module ray_obb_slab_intersect
    import rosi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rosi_box_if.sink              box,
    rosi_hit_if.source            result
);

    // Stage map: three front stages (offset, products, projections), one
    // numerator stage, divider set-up plus 31 divider steps, ordering stage
    // and the output register.
    localparam int DIV_STEPS = 31;
    localparam int S1  = 0;
    localparam int S2  = 1;
    localparam int S3  = 2;
    localparam int S4  = 3;
    localparam int D0  = 4;
    localparam int F1  = D0 + DIV_STEPS + 1;
    localparam int OUT = F1 + 1;
    localparam int NST = OUT + 1;

    typedef struct packed {
        logic [2:0][32:0]       p;       // center minus origin, x y z
        logic [2:0][AXIS_W-1:0] axis;
        logic [2:0][HALF_W-1:0] half;
    } s1_t;

    typedef struct packed {
        logic [2:0][2:0][48:0]  pe;      // axis component times offset
        logic [2:0][2:0][47:0]  pf;      // axis component times direction
        logic [2:0][HALF_W-1:0] half;
    } s2_t;

    typedef struct packed {
        logic [2:0][50:0]       e;       // projected offset, Q.31
        logic [2:0][49:0]       f;       // projected direction, Q.31
        logic [2:0][HALF_W-1:0] half;
    } s3_t;

    typedef struct packed {
        logic [5:0][50:0] un;            // |e + h| and |e - h| per axis
        logic [2:0][49:0] ud;            // |f| per axis
        logic [5:0]       neg;
        logic [2:0]       para;
        logic [2:0]       pmiss;
    } s4_t;

    typedef struct packed {
        logic        ovf;
        logic        neg;
        logic [49:0] rem;
        logic [49:0] ud;
        logic [30:0] num;
        logic [30:0] q;
    } dlane_t;

    typedef struct packed {
        dlane_t [5:0] lane;
        logic [2:0]   para;
        logic [2:0]   pmiss;
    } dstage_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] lo;
        logic [2:0][POS_W-1:0] hi;
        logic [2:0]            para;
        logic [2:0]            pmiss;
    } f1_t;

    // One restoring step: bring down the next numerator bit, subtract the
    // divisor when it fits.
    function automatic dlane_t div_step(dlane_t l);
        logic [50:0] r2;
        logic        ge;
        dlane_t      o;
        o     = l;
        r2    = {l.rem, l.num[30]};
        ge    = (r2 >= {1'b0, l.ud});
        o.rem = ge ? 50'(r2 - {1'b0, l.ud}) : r2[49:0];
        o.q   = {l.q[29:0], ge};
        o.num = {l.num[29:0], 1'b0};
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [POS_W-1:0] direction_x_reg, direction_y_reg, direction_z_reg;
    logic [THR_W-1:0]        thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            direction_x_reg <= 32'sd65536;
            direction_y_reg <= '0;
            direction_z_reg <= '0;
            thr_reg         <= 17'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                CFG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                CFG_DIRECTION_X: direction_x_reg <= cfg_data;
                CFG_DIRECTION_Y: direction_y_reg <= cfg_data;
                CFG_DIRECTION_Z: direction_z_reg <= cfg_data;
                CFG_PAR_THRESH:  thr_reg         <= cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage may load when it is empty or when the stage
    // after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[OUT] = ~vld_reg[OUT] | result.ready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = ~vld_reg[k] | en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= box.valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign box.ready = en[S1];

    // ------------------------------------------------------------------
    // Stage 1: offset of the box center from the ray origin.
    // ------------------------------------------------------------------
    s1_t s1_next, s1_reg;

    always_comb
    begin
        s1_next.p[0] = {box.center_x[31], box.center_x} - {origin_x_reg[31], origin_x_reg};
        s1_next.p[1] = {box.center_y[31], box.center_y} - {origin_y_reg[31], origin_y_reg};
        s1_next.p[2] = {box.center_z[31], box.center_z} - {origin_z_reg[31], origin_z_reg};
        s1_next.axis[0] = box.axis_first;
        s1_next.axis[1] = box.axis_second;
        s1_next.axis[2] = box.axis_third;
        s1_next.half[0] = box.half_first;
        s1_next.half[1] = box.half_second;
        s1_next.half[2] = box.half_third;
    end

    // ------------------------------------------------------------------
    // Stage 2: the eighteen component products, exact.
    // ------------------------------------------------------------------
    s2_t s2_next, s2_reg;

    always_comb
    begin
        logic signed [COMP_W-1:0] a;
        logic signed [32:0]       pv;
        logic signed [POS_W-1:0]  dv;
        logic signed [48:0]       prod_e;
        logic signed [47:0]       prod_f;
        s2_next.half = s1_reg.half;
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a  = s1_reg.axis[i][AXIS_W-1-COMP_W*c -: COMP_W];
                pv = s1_reg.p[c];
                dv = (c == 0) ? direction_x_reg :
                     (c == 1) ? direction_y_reg : direction_z_reg;
                prod_e = a * pv;
                prod_f = a * dv;
                s2_next.pe[i][c] = prod_e;
                s2_next.pf[i][c] = prod_f;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: projections on each box axis.
    // ------------------------------------------------------------------
    s3_t s3_next, s3_reg;

    always_comb
    begin
        logic signed [50:0] e;
        logic signed [49:0] f;
        s3_next.half = s2_reg.half;
        for (int i = 0; i < 3; i++)
        begin
            e = $signed(s2_reg.pe[i][0]) + $signed(s2_reg.pe[i][1])
              + $signed(s2_reg.pe[i][2]);
            f = $signed(s2_reg.pf[i][0]) + $signed(s2_reg.pf[i][1])
              + $signed(s2_reg.pf[i][2]);
            s3_next.e[i] = e;
            s3_next.f[i] = f;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slab numerators, magnitudes, signs and the parallel tests.
    // ------------------------------------------------------------------
    s4_t s4_next, s4_reg;

    always_comb
    begin
        logic signed [50:0] e, hw, n1, n2;
        logic signed [49:0] f, thrw;
        thrw = $signed({18'b0, thr_reg, 15'b0});
        for (int i = 0; i < 3; i++)
        begin
            e  = $signed(s3_reg.e[i]);
            f  = $signed(s3_reg.f[i]);
            hw = $signed({5'b0, s3_reg.half[i], 15'b0});
            n1 = e + hw;
            n2 = e - hw;
            s4_next.un[2*i]    = n1[50] ? 51'(-n1) : n1;
            s4_next.un[2*i+1]  = n2[50] ? 51'(-n2) : n2;
            s4_next.neg[2*i]   = n1[50] ^ f[49];
            s4_next.neg[2*i+1] = n2[50] ^ f[49];
            s4_next.ud[i]      = f[49] ? 50'(-f) : f;
            s4_next.para[i]    = !((f > thrw) || (f < -thrw));
            s4_next.pmiss[i]   = (e < -hw) || (e > hw);
        end
    end

    // ------------------------------------------------------------------
    // Divider: set-up stage, then one quotient bit per stage. The quotient
    // is the Q16.16 slab distance; it saturates once it reaches 2^31, which
    // is known up front from the top numerator bits.
    // ------------------------------------------------------------------
    dstage_t d_next [DIV_STEPS+1];
    dstage_t d_reg  [DIV_STEPS+1];

    always_comb
    begin
        d_next[0].para  = s4_reg.para;
        d_next[0].pmiss = s4_reg.pmiss;
        for (int k = 0; k < 6; k++)
        begin
            d_next[0].lane[k].ud  = s4_reg.ud[k/2];
            d_next[0].lane[k].neg = s4_reg.neg[k];
            d_next[0].lane[k].rem = {14'b0, s4_reg.un[k][50:15]};
            d_next[0].lane[k].ovf = ({14'b0, s4_reg.un[k][50:15]} >= s4_reg.ud[k/2]);
            d_next[0].lane[k].num = {s4_reg.un[k][14:0], 16'b0};
            d_next[0].lane[k].q   = '0;
        end
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            d_next[j].para  = d_reg[j-1].para;
            d_next[j].pmiss = d_reg[j-1].pmiss;
            for (int k = 0; k < 6; k++)
                d_next[j].lane[k] = div_step(d_reg[j-1].lane[k]);
        end
    end

    // ------------------------------------------------------------------
    // Ordering stage: signed, saturated slab distances, near one first.
    // ------------------------------------------------------------------
    f1_t f1_next, f1_reg;

    always_comb
    begin
        logic signed [POS_W-1:0] t [2];
        dlane_t                  l;
        f1_next.para  = d_reg[DIV_STEPS].para;
        f1_next.pmiss = d_reg[DIV_STEPS].pmiss;
        for (int i = 0; i < 3; i++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                l = d_reg[DIV_STEPS].lane[2*i+s];
                if (l.ovf)
                    t[s] = l.neg ? Q_MIN : Q_MAX;
                else
                    t[s] = l.neg ? -$signed({1'b0, l.q}) : $signed({1'b0, l.q});
            end
            if (t[0] > t[1])
            begin
                f1_next.lo[i] = t[1];
                f1_next.hi[i] = t[0];
            end
            else
            begin
                f1_next.lo[i] = t[0];
                f1_next.hi[i] = t[1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: narrow the entry/exit range axis by axis. Once a miss
    // is seen the result stays a miss, so no early exit is needed.
    // ------------------------------------------------------------------
    logic                    hit_next, hit_reg;
    logic signed [POS_W-1:0] dist_next, dist_reg;

    always_comb
    begin
        logic signed [POS_W-1:0] tmin, tmax, lo, hi;
        logic                    ok;
        tmin = Q_MIN;
        tmax = Q_MAX;
        ok   = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            lo = f1_reg.lo[i];
            hi = f1_reg.hi[i];
            if (!f1_reg.para[i])
            begin
                if (lo > tmin)
                    tmin = lo;
                if (hi < tmax)
                    tmax = hi;
                if ((tmin > tmax) || (tmax < 0))
                    ok = 1'b0;
            end
            else if (f1_reg.pmiss[i])
                ok = 1'b0;
        end
        hit_next  = ok;
        dist_next = !ok ? '0 : ((tmin > 0) ? tmin : tmax);
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[S1])
            s1_reg <= s1_next;
        if (en[S2])
            s2_reg <= s2_next;
        if (en[S3])
            s3_reg <= s3_next;
        if (en[S4])
            s4_reg <= s4_next;
        for (int j = 0; j <= DIV_STEPS; j++)
            if (en[D0+j])
                d_reg[j] <= d_next[j];
        if (en[F1])
            f1_reg <= f1_next;
        if (en[OUT])
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign result.valid    = vld_reg[OUT];
    assign result.hit      = hit_reg;
    assign result.distance = dist_reg;

endmodule
